### rtl/fir_mc_pkg.sv
// Shared constants, types and the rounding function of the multichannel FIR filter.
package fir_mc_pkg;

   localparam int TAPS      = 64;
   localparam int CHANNELS  = 2;

   localparam int SAMPLE_W  = 24;
   localparam int FRAC_W    = 23;
   localparam int TAP_IDX_W = 6;
   localparam int PROD_W    = 2 * SAMPLE_W;
   localparam int ACC_W     = PROD_W + $clog2(TAPS);

   localparam int PTR_W      = $clog2(TAPS);
   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LINE_AW    = CH_IDX_W + PTR_W;
   localparam int LINE_DEPTH = 1 << LINE_AW;

   localparam int Q_MAX      = (1 << (SAMPLE_W - 1)) - 1;
   localparam int Q_MIN      = -(1 << (SAMPLE_W - 1));
   localparam int ROUND_BIAS = 1 << (FRAC_W - 1);

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   typedef struct packed {
      logic load_coef;
      logic start;
      logic issue;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic last_tap;
      logic pipe_busy;
      logic out_busy;
   } dp_status_type;

   function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]        biased;
      logic signed [ACC_W-FRAC_W:0] q;
      logic signed [SAMPLE_W-1:0]   res;
      biased = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(ROUND_BIAS));
      q      = biased[ACC_W:FRAC_W];
      if (q > $signed((ACC_W - FRAC_W + 1)'(Q_MAX))) begin
         res = SAMPLE_W'(Q_MAX);
      end else if (q < $signed((ACC_W - FRAC_W + 1)'(Q_MIN))) begin
         res = SAMPLE_W'(Q_MIN);
      end else begin
         res = q[SAMPLE_W-1:0];
      end
      return res;
   endfunction

endpackage

### rtl/fir_mc_if.sv
// Request and response channel interfaces of the multichannel FIR filter.
interface fir_mc_req_if import fir_mc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic                       channel;
   logic [TAP_IDX_W-1:0]       tap_index;
   logic signed [SAMPLE_W-1:0] value;

   modport source(output valid, op, channel, tap_index, value, input ready);
   modport sink(input valid, op, channel, tap_index, value, output ready);
endinterface

interface fir_mc_rsp_if import fir_mc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] filtered;
   logic                       channel_out;

   modport source(output valid, filtered, channel_out, input ready);
   modport sink(input valid, filtered, channel_out, output ready);
endinterface

### rtl/fir_filter_multichannel_top.sv
// Top level of the multichannel FIR filter: a single MAC over a shared coefficient RAM.
// A sample transfer runs one tap at a time through the single multiply-accumulate unit,
// then via the read and product registers and the accumulator into the result register,
// where a result waits until taken. One sample is in flight; the next item is taken
// after its result is loaded, or the cycle after a coefficient load.
// Reset clears state, delay-line pointers and the valid bits, so every store reads as zero.
module fir_filter_multichannel_top import fir_mc_pkg::*; (
   input logic         clock,
   input logic         reset,
   fir_mc_req_if.sink  req_chan,
   fir_mc_rsp_if.source rsp_chan
);
   dp_cmd_type    cmd;
   dp_status_type status;

   fir_mc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_op      (req_chan.op),
      .req_channel (req_chan.channel),
      .req_ready   (req_chan.ready),
      .status      (status),
      .cmd         (cmd)
   );

   fir_mc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_channel     (req_chan.channel),
      .req_tap_index   (req_chan.tap_index),
      .req_value       (req_chan.value),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_filtered    (rsp_chan.filtered),
      .rsp_channel_out (rsp_chan.channel_out)
   );
endmodule

### rtl/fir_mc_ram.sv
// Generic simple dual-port RAM with registered read.
module fir_mc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/fir_mc_ctrl.sv
// Controller state machine of the multichannel FIR filter.
module fir_mc_ctrl import fir_mc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_op,
   input  logic          req_channel,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MAC   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       ch_ok;

   assign ch_ok = 32'(req_channel) < 32'(CHANNELS);

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  cmd.load_coef = 1'b1;
               end else if (ch_ok) begin
                  cmd.start = 1'b1;
                  state_in  = S_MAC;
               end
            end
         end
         S_MAC: begin
            cmd.issue = 1'b1;
            if (status.last_tap) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_last_tap_drains: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && status.last_tap) |=> (state_ff == S_DRAIN))
      else $error("last tap did not move to drain");

   a_out_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (state_ff == S_IDLE && !cmd.issue))
      else $error("result load did not return to idle");

   a_ready_in_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE))
      else $error("request ready outside idle");
endmodule

### rtl/fir_mc_datapath.sv
// Datapath of the multichannel FIR filter: stores, MAC pipeline and result register.
module fir_mc_datapath import fir_mc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic                       req_channel,
   input  logic [TAP_IDX_W-1:0]       req_tap_index,
   input  logic signed [SAMPLE_W-1:0] req_value,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W-1:0] rsp_filtered,
   output logic                       rsp_channel_out
);
   logic [PTR_W-1:0]           ptr_ff [CHANNELS];
   logic [PTR_W-1:0]           rd_ptr_ff;
   logic [PTR_W-1:0]           tap_cnt_ff;
   logic                       chan_ff;
   logic [TAPS-1:0]            coef_vld_ff;
   logic [LINE_DEPTH-1:0]      line_vld_ff;
   logic                       coef_hit_ff;
   logic                       line_hit_ff;
   logic                       rd_v_ff;
   logic                       prod_v_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] filtered_ff;
   logic                       chan_out_ff;

   logic [CH_IDX_W-1:0]        req_ch_idx;
   logic [PTR_W-1:0]           wr_ptr;
   logic [PTR_W-1:0]           wr_ptr_next;
   logic [PTR_W-1:0]           rd_ptr_next;
   logic [LINE_AW-1:0]         line_wr_addr;
   logic [LINE_AW-1:0]         line_rd_addr;
   logic                       tap_ok;
   logic                       coef_we;
   logic [PTR_W-1:0]           coef_wr_addr;
   logic [SAMPLE_W-1:0]        coef_rdata;
   logic [SAMPLE_W-1:0]        line_rdata;
   logic signed [SAMPLE_W-1:0] coef_op;
   logic signed [SAMPLE_W-1:0] line_op;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(TAPS - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign req_ch_idx   = CH_IDX_W'(req_channel);
   assign wr_ptr       = ptr_ff[req_ch_idx];
   assign wr_ptr_next  = wrap_inc(wr_ptr);
   assign rd_ptr_next  = wrap_inc(rd_ptr_ff);
   assign line_wr_addr = {req_ch_idx, wr_ptr};
   assign line_rd_addr = {CH_IDX_W'(chan_ff), rd_ptr_ff};
   assign tap_ok       = 32'(req_tap_index) < 32'(TAPS);
   assign coef_we      = cmd.load_coef && tap_ok;
   assign coef_wr_addr = PTR_W'(req_tap_index);

   fir_mc_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.issue),
      .rd_addr (tap_cnt_ff),
      .rd_data (coef_rdata)
   );

   fir_mc_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.start),
      .wr_addr (line_wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.issue),
      .rd_addr (line_rd_addr),
      .rd_data (line_rdata)
   );

   assign coef_op = coef_hit_ff ? $signed(coef_rdata) : '0;
   assign line_op = line_hit_ff ? $signed(line_rdata) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            ptr_ff[c] <= '0;
         end
         coef_vld_ff  <= '0;
         line_vld_ff  <= '0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (coef_we) begin
            coef_vld_ff[coef_wr_addr] <= 1'b1;
         end
         if (cmd.start) begin
            line_vld_ff[line_wr_addr] <= 1'b1;
            ptr_ff[req_ch_idx]        <= wr_ptr_next;
         end
         rd_v_ff   <= cmd.issue;
         prod_v_ff <= rd_v_ff;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_ptr_ff  <= wr_ptr_next;
         tap_cnt_ff <= '0;
         chan_ff    <= req_channel;
      end else if (cmd.issue) begin
         rd_ptr_ff  <= rd_ptr_next;
         tap_cnt_ff <= tap_cnt_ff + PTR_W'(1);
      end
      if (cmd.issue) begin
         coef_hit_ff <= coef_vld_ff[tap_cnt_ff];
         line_hit_ff <= line_vld_ff[line_rd_addr];
      end
      prod_ff <= coef_op * line_op;
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.load_out) begin
         filtered_ff <= round_sat(acc_ff);
         chan_out_ff <= chan_ff;
      end
   end

   assign status.last_tap  = tap_cnt_ff == PTR_W'(TAPS - 1);
   assign status.pipe_busy = rd_v_ff || prod_v_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filtered    = filtered_ff;
   assign rsp_channel_out = chan_out_ff;

   a_start_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (!rd_v_ff && !prod_v_ff && !cmd.issue))
      else $error("sample started with the MAC pipeline busy");

   a_out_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rd_v_ff && !prod_v_ff))
      else $error("result loaded before accumulation finished");

   a_issue_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && !status.last_tap) |=> (tap_cnt_ff == $past(tap_cnt_ff) + PTR_W'(1)))
      else $error("tap counter did not advance");
endmodule
